// ===== hdl/fsrc_pkg.sv =====
// Shared types, codes and the CRC step for the framed serial receiver.
// Used by fsrc_outq and framed_serial_receiver_crc16_top; depends on nothing.
package fsrc_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned LEN_OUT_W = 7;
  // Width for length and index compares (length byte is 8 bits, depth up to 256)
  localparam int unsigned LEN_CMP_W = 9;

  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_MSB  = 16'h8000;
  localparam logic [DATA_W-1:0] MIN_LEN  = 8'd3;

  // Receive phases
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_TRAIN = 2'd1,
    PH_MSG   = 2'd2,
    PH_HELD  = 2'd3
  } phase_e;

  // Input operations
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_READ    = 2'd3
  } opcode_e;

  // Outcome codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CRC     = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TRAIN_CHAR = 2'd0;
  localparam logic [1:0] CFG_MIN_TRAIN  = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

  // One result item
  typedef struct packed {
    logic [1:0]           receive_state;
    logic                 frame_ready;
    logic [1:0]           error_code;
    logic [DATA_W-1:0]    crc_error_total;
    logic [LEN_OUT_W-1:0] frame_length;
    logic [DATA_W-1:0]    read_data;
  } result_t;

  // One byte of CRC-16-CCITT, byte bit-reversed before it is folded in
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] rev;
    logic [CRC_W-1:0]  c;
    for (int k = 0; k < DATA_W; k++) begin
      rev[k] = b[DATA_W-1-k];
    end
    c = crc ^ {rev, 8'h00};
    for (int k = 0; k < DATA_W; k++) begin
      if ((c & CRC_MSB) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/fsrc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fsrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fsrc_outq.sv =====
// Two-entry result queue in front of the output channel.
// Depends on fsrc_pkg (result_t).
module fsrc_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fsrc_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fsrc_pkg::result_t out_data_o
);

  fsrc_pkg::result_t entry_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              pop;

  assign pop         = (count_q != 2'd0) && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign full_o      = (count_q == 2'd2);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/framed_serial_receiver_crc16_top.sv =====
// Framed serial receiver with CRC-16-CCITT check; uses fsrc_pkg, fsrc_ram, fsrc_outq.
// Throughput: one item per cycle unless the input stalls (middle stage full and queue
// full); the frame buffer RAM has one write and one read port and each item uses at
// most one of them, with registered read data.
// Reset: asynchronous, clears phase, counters, CRC and configuration; the frame
// buffer is not cleared and needs no clearing pass.
module framed_serial_receiver_crc16_top #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] rx_byte_i,
  input  logic [5:0] read_index_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] receive_state_o,
  output logic       frame_ready_o,
  output logic [1:0] error_code_o,
  output logic [7:0] crc_error_total_o,
  output logic [6:0] frame_length_o,
  output logic [7:0] read_data_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned IW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CW = fsrc_pkg::LEN_CMP_W;

  // Configuration registers
  logic [7:0] train_char_q;
  logic [7:0] min_train_q;
  logic [6:0] max_len_q;
  logic [7:0] timeout_q;

  // Receiver state
  fsrc_pkg::phase_e phase_q, phase_d;
  logic [7:0]       train_cnt_q, train_cnt_d;
  logic [IW-1:0]    byte_idx_q, byte_idx_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       prev_q, prev_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       tick_q, tick_d;
  logic             held_q, held_d;
  logic [1:0]       err_q, err_d;
  logic [7:0]       fail_q, fail_d;

  // Frame buffer port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Stage between accept and queue (read data arrives here)
  logic              s1_valid_q;
  fsrc_pkg::result_t s1_res_q;
  logic              s1_rd_q;
  fsrc_pkg::result_t res_new;
  fsrc_pkg::result_t push_res;
  logic              rd_sel;
  logic              q_full;
  logic              push;
  fsrc_pkg::result_t out_res;

  logic in_xfer;
  logic len_ok;
  logic read_in_range;
  logic cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      train_char_q <= 8'd0;
      min_train_q  <= 8'd2;
      max_len_q    <= 7'd64;
      timeout_q    <= 8'd25;
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        fsrc_pkg::CFG_TRAIN_CHAR: train_char_q <= cfg_data_i;
        fsrc_pkg::CFG_MIN_TRAIN:  min_train_q  <= cfg_data_i;
        fsrc_pkg::CFG_MAX_LENGTH: max_len_q    <= cfg_data_i[6:0];
        fsrc_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stall only when the middle stage is full and the queue has no room
  assign in_ready_o = !(s1_valid_q && q_full);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign len_ok = (rx_byte_i >= fsrc_pkg::MIN_LEN) &&
                  (rx_byte_i <= {1'b0, max_len_q}) &&
                  (CW'(rx_byte_i) <= CW'(BUFFER_DEPTH)) &&
                  (train_cnt_q >= min_train_q);

  assign read_in_range = (int'(read_index_i) < BUFFER_DEPTH);
  assign ram_raddr     = AW'(read_index_i);

  // Next state, buffer access and result for the accepted item
  always_comb begin
    phase_d     = phase_q;
    train_cnt_d = train_cnt_q;
    byte_idx_d  = byte_idx_q;
    len_d       = len_q;
    prev_d      = prev_q;
    crc_d       = crc_q;
    tick_d      = tick_q;
    held_d      = held_q;
    err_d       = err_q;
    fail_d      = fail_q;
    ram_we      = 1'b0;
    ram_waddr   = byte_idx_q[AW-1:0];
    ram_wdata   = rx_byte_i;
    ram_re      = 1'b0;
    rd_sel      = 1'b0;

    if (in_xfer) begin
      unique case (fsrc_pkg::opcode_e'(opcode_i))
        fsrc_pkg::OP_BYTE: begin
          unique case (phase_q)
            fsrc_pkg::PH_HUNT: begin
              if (rx_byte_i == train_char_q) begin
                phase_d     = fsrc_pkg::PH_TRAIN;
                train_cnt_d = 8'd1;
                tick_d      = 8'd0;
              end
            end
            fsrc_pkg::PH_TRAIN: begin
              if (rx_byte_i == train_char_q) begin
                if (train_cnt_q != 8'hFF) begin
                  train_cnt_d = train_cnt_q + 8'd1;
                end
              end else if (len_ok) begin
                // length byte opens the frame at buffer position 0
                phase_d    = fsrc_pkg::PH_MSG;
                len_d      = rx_byte_i;
                byte_idx_d = IW'(1);
                crc_d      = fsrc_pkg::crc16_byte(fsrc_pkg::CRC_INIT, rx_byte_i);
                ram_we     = 1'b1;
                ram_waddr  = '0;
              end else begin
                phase_d    = fsrc_pkg::PH_HUNT;
                byte_idx_d = '0;
                held_d     = 1'b0;
              end
            end
            fsrc_pkg::PH_MSG: begin
              ram_we     = 1'b1;
              byte_idx_d = byte_idx_q + IW'(1);
              prev_d     = rx_byte_i;
              // CRC covers all but the last two bytes
              if (CW'(byte_idx_q) + CW'(2) < CW'(len_q)) begin
                crc_d = fsrc_pkg::crc16_byte(crc_q, rx_byte_i);
              end
              if (CW'(byte_idx_q) + CW'(1) >= CW'(len_q)) begin
                if (crc_q == {prev_q, rx_byte_i}) begin
                  phase_d = fsrc_pkg::PH_HELD;
                  held_d  = 1'b1;
                  err_d   = fsrc_pkg::ERR_NONE;
                end else begin
                  if (fail_q != 8'hFF) begin
                    fail_d = fail_q + 8'd1;
                  end
                  err_d      = fsrc_pkg::ERR_CRC;
                  phase_d    = fsrc_pkg::PH_HUNT;
                  byte_idx_d = '0;
                  held_d     = 1'b0;
                end
              end
            end
            fsrc_pkg::PH_HELD: ;
            default: ;
          endcase
        end
        fsrc_pkg::OP_TICK: begin
          if (phase_q == fsrc_pkg::PH_TRAIN || phase_q == fsrc_pkg::PH_MSG) begin
            if (tick_q >= timeout_q) begin
              err_d      = fsrc_pkg::ERR_TIMEOUT;
              phase_d    = fsrc_pkg::PH_HUNT;
              byte_idx_d = '0;
              held_d     = 1'b0;
            end else begin
              tick_d = tick_q + 8'd1;
            end
          end
        end
        fsrc_pkg::OP_RELEASE: begin
          if (phase_q == fsrc_pkg::PH_HELD) begin
            phase_d    = fsrc_pkg::PH_HUNT;
            byte_idx_d = '0;
            held_d     = 1'b0;
          end
        end
        fsrc_pkg::OP_READ: begin
          if (read_in_range) begin
            ram_re = 1'b1;
            rd_sel = 1'b1;
          end
        end
        default: ;
      endcase
    end

    res_new.receive_state   = phase_d;
    res_new.frame_ready     = held_d;
    res_new.error_code      = err_d;
    res_new.crc_error_total = fail_d;
    res_new.frame_length    = (phase_d == fsrc_pkg::PH_HELD) ? len_d[6:0] : 7'd0;
    res_new.read_data       = 8'd0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fsrc_pkg::PH_HUNT;
      train_cnt_q <= 8'd0;
      byte_idx_q  <= '0;
      len_q       <= 8'd0;
      crc_q       <= fsrc_pkg::CRC_INIT;
      tick_q      <= 8'd0;
      held_q      <= 1'b0;
      err_q       <= fsrc_pkg::ERR_NONE;
      fail_q      <= 8'd0;
    end else begin
      phase_q     <= phase_d;
      train_cnt_q <= train_cnt_d;
      byte_idx_q  <= byte_idx_d;
      len_q       <= len_d;
      crc_q       <= crc_d;
      tick_q      <= tick_d;
      held_q      <= held_d;
      err_q       <= err_d;
      fail_q      <= fail_d;
    end
  end

  // Second-to-last byte of the frame, for the CRC compare
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

  // Frame buffer
  fsrc_ram #(
    .WIDTH(fsrc_pkg::DATA_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Middle stage: waits for the RAM read, then moves into the queue
  assign push = s1_valid_q && (!q_full || (out_valid_o && out_ready_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (push) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_res_q <= res_new;
      s1_rd_q  <= rd_sel;
    end
  end

  always_comb begin
    push_res           = s1_res_q;
    push_res.read_data = s1_rd_q ? ram_rdata : 8'd0;
  end

  fsrc_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_res),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign receive_state_o   = out_res.receive_state;
  assign frame_ready_o     = out_res.frame_ready;
  assign error_code_o      = out_res.error_code;
  assign crc_error_total_o = out_res.crc_error_total;
  assign frame_length_o    = out_res.frame_length;
  assign read_data_o       = out_res.read_data;

`ifndef SYNTHESIS
  // Good-frame flag tracks the held phase
  a_held_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == (phase_q == fsrc_pkg::PH_HELD))
    else $error("held flag and phase disagree");

  // Write position stays inside the announced frame length
  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == fsrc_pkg::PH_MSG) |-> (CW'(byte_idx_q) < CW'(len_q)))
    else $error("frame write index past length");

  // Read data must not change while its item waits in the middle stage
  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !push) |=> $stable(ram_rdata))
    else $error("buffer read data lost while stalled");

  // CRC failure count never decreases
  a_fail_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (fail_q >= $past(fail_q)))
    else $error("CRC failure count went down");
`endif

endmodule
